/* rtl/counting_semaphore_wait_queue_defines.svh */
// Assertion macros for the counting semaphore wait queue
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_DEFINES_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

`define CSEMWQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("csemwq assertion failed");

`define CSEMWQ_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("csemwq forbidden condition");

`else

`define CSEMWQ_ASSERT(lbl, clk, rst_n, prop)

`define CSEMWQ_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

/* rtl/csemwq_pkg.sv */
// Shared constants, codes and controller/datapath interface types
package csemwq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int COUNT_BITS  = 16;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int FILL_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_DOWN   = 2'd0,
    OP_UP     = 2'd1,
    OP_REINIT = 2'd2
  } op_e_t;

  typedef enum logic [2:0] {
    ST_GRANTED     = 3'd0,
    ST_QUEUED      = 3'd1,
    ST_RAISED      = 3'd2,
    ST_HANDED      = 3'd3,
    ST_QUEUE_FULL  = 3'd4,
    ST_OVERFLOW    = 3'd5,
    ST_REINIT_DONE = 3'd6,
    ST_REINIT_REF  = 3'd7
  } status_e_t;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_TAKE   = 3'd1,
    ACT_ENQ    = 3'd2,
    ACT_RAISE  = 3'd3,
    ACT_DEQ    = 3'd4,
    ACT_RELOAD = 3'd5
  } act_e_t;

  typedef struct packed {
    logic      load;
    logic      exec;
    act_e_t    action;
    status_e_t status;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_max;
    logic q_empty;
    logic q_full;
  } dp_stat_t;

endpackage

/* rtl/csemwq_dp.sv */
// Datapath: unit count, wait queue memory and pointers, result register
`include "counting_semaphore_wait_queue_defines.svh"

module csemwq_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  csemwq_pkg::dp_cmd_t                 cmd,
  output csemwq_pkg::dp_stat_t                st,
  input  logic [csemwq_pkg::ID_BITS-1:0]      in_tid,
  input  logic [csemwq_pkg::COUNT_BITS-1:0]   init_count,
  output logic [2:0]                          res_status,
  output logic [csemwq_pkg::ID_BITS-1:0]      res_woken,
  output logic [csemwq_pkg::COUNT_BITS-1:0]   res_count,
  output logic [csemwq_pkg::FILL_BITS-1:0]    res_fill
);
  import csemwq_pkg::*;

  logic [ID_BITS-1:0]    mem [QUEUE_DEPTH];
  logic [ID_BITS-1:0]    tid_r;
  logic [ID_BITS-1:0]    rd_r;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [PTR_BITS-1:0]   head_r, head_nxt;
  logic [PTR_BITS-1:0]   tail_r, tail_nxt;
  logic [FILL_BITS-1:0]  fill_r, fill_nxt;
  logic [2:0]            status_r;
  logic [ID_BITS-1:0]    woken_r;
  logic [COUNT_BITS-1:0] rcount_r;
  logic [FILL_BITS-1:0]  rfill_r;

  function automatic logic [PTR_BITS-1:0] next_pos(input logic [PTR_BITS-1:0] p);
    return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign st.count_zero = (count_r == '0);
  assign st.count_max  = (count_r == '1);
  assign st.q_empty    = (fill_r == '0);
  assign st.q_full     = (fill_r == FILL_BITS'(QUEUE_DEPTH));

  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    fill_nxt  = fill_r;
    case (cmd.action)
      ACT_TAKE:   count_nxt = count_r - 1'b1;
      ACT_RAISE:  count_nxt = count_r + 1'b1;
      ACT_RELOAD: count_nxt = init_count;
      ACT_ENQ: begin
        tail_nxt = next_pos(tail_r);
        fill_nxt = fill_r + 1'b1;
      end
      ACT_DEQ: begin
        head_nxt = next_pos(head_r);
        fill_nxt = fill_r - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      fill_r  <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && cmd.action == ACT_ENQ) begin
      mem[tail_r] <= tid_r;
    end
    if (cmd.load) begin
      rd_r  <= mem[head_r];
      tid_r <= in_tid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= cmd.status;
      woken_r  <= (cmd.action == ACT_DEQ) ? rd_r : '0;
      rcount_r <= count_nxt;
      rfill_r  <= fill_nxt;
    end
  end

  assign res_status = status_r;
  assign res_woken  = woken_r;
  assign res_count  = rcount_r;
  assign res_fill   = rfill_r;

  `CSEMWQ_NEVER(a_fill_bound, clk, rst_n, fill_r > FILL_BITS'(QUEUE_DEPTH))
  `CSEMWQ_ASSERT(a_take_dec, clk, rst_n,
    (cmd.exec && cmd.action == ACT_TAKE) |=> (count_r == $past(count_r) - 1'b1))
  `CSEMWQ_ASSERT(a_enq_fill, clk, rst_n,
    (cmd.exec && cmd.action == ACT_ENQ) |=> (fill_r == $past(fill_r) + 1'b1))

endmodule

/* rtl/csemwq_ctrl.sv */
// Controller: request handshake, sequencing and action decode
`include "counting_semaphore_wait_queue_defines.svh"

module csemwq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [1:0]            in_op,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  csemwq_pkg::dp_stat_t  st,
  output csemwq_pkg::dp_cmd_t   cmd
);
  import csemwq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  op_e_t  op_r;
  logic   out_valid_r;
  logic   accept;

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.load   = accept;
    cmd.exec   = (state_r == S_EXEC);
    cmd.action = ACT_NONE;
    cmd.status = ST_REINIT_REF;
    case (op_r)
      OP_DOWN: begin
        if (!st.count_zero) begin
          cmd.action = ACT_TAKE;
          cmd.status = ST_GRANTED;
        end else if (st.q_full) begin
          cmd.status = ST_QUEUE_FULL;
        end else begin
          cmd.action = ACT_ENQ;
          cmd.status = ST_QUEUED;
        end
      end
      OP_UP: begin
        if (!st.q_empty) begin
          cmd.action = ACT_DEQ;
          cmd.status = ST_HANDED;
        end else if (st.count_max) begin
          cmd.status = ST_OVERFLOW;
        end else begin
          cmd.action = ACT_RAISE;
          cmd.status = ST_RAISED;
        end
      end
      OP_REINIT: begin
        if (st.q_empty) begin
          cmd.action = ACT_RELOAD;
          cmd.status = ST_REINIT_DONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EXEC) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= op_e_t'(in_op);
    end
  end

  `CSEMWQ_ASSERT(a_accept_exec, clk, rst_n, accept |=> (state_r == S_EXEC))
  `CSEMWQ_ASSERT(a_exec_result, clk, rst_n, (state_r == S_EXEC) |=> out_valid_r)
  `CSEMWQ_NEVER(a_exec_blocked, clk, rst_n, (state_r == S_EXEC) && out_valid_r)
  `CSEMWQ_NEVER(a_enq_full, clk, rst_n, cmd.exec && cmd.action == ACT_ENQ && st.q_full)
  `CSEMWQ_NEVER(a_deq_empty, clk, rst_n, cmd.exec && cmd.action == ACT_DEQ && st.q_empty)

endmodule

/* rtl/counting_semaphore_wait_queue.sv */
// Top level: counting semaphore with FIFO wait queue of blocked thread ids
//
//   channel  direction  handshake            payload
//   in       slave      in_tvalid/in_tready  opcode, thread_id
//   out      master     out_tvalid/out_tready status, woken_thread, count_now, waiters_now
//   cfg      APB        cfg_psel/cfg_penable initial_count at byte address 0
//
// A new request is taken only once the last one has executed: the accept cycle latches the request and reads the
// head entry of the wait queue memory, the execute cycle updates count and pointers
// and loads the output register. Reset is synchronous with no clearing pass; the
// queue memory holds no reset value. While a result waits with out_tready low, no
// new request is taken.
module counting_semaphore_wait_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] thread_id
  input  logic [1:0]  in_tuser,    // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [7:0] woken_thread, [23:8] count_now, [28:24] waiters_now
  output logic [2:0]  out_tuser,   // [2:0] status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import csemwq_pkg::*;

  localparam logic CFG_IDX_INIT = 1'b0;

  dp_cmd_t               cmd;
  dp_stat_t              st;
  logic [COUNT_BITS-1:0] init_r;
  logic [ID_BITS-1:0]    woken;
  logic [COUNT_BITS-1:0] count_now;
  logic [FILL_BITS-1:0]  fill_now;
  logic                  cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= '0;
    end else if (cfg_wr && cfg_paddr[2] == CFG_IDX_INIT) begin
      init_r <= cfg_pwdata[COUNT_BITS-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_INIT) ? 32'(init_r) : '0;

  csemwq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  csemwq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tid     (in_tdata),
    .init_count (init_r),
    .res_status (out_tuser),
    .res_woken  (woken),
    .res_count  (count_now),
    .res_fill   (fill_now)
  );

  assign out_tdata = {3'b000, fill_now, count_now, woken};

endmodule
